### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/zctd_pkg.sv
// ----------------------------------------------------------------------------
// zctd_pkg
// types, result kind codes and alphabet lookup for the packed text decoder
// ----------------------------------------------------------------------------
package zctd_pkg;

    // result kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_ABBREV = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    // special code values
    localparam logic [4:0] CODE_SPACE     = 5'd0;
    localparam logic [4:0] CODE_LAST_ABBR = 5'd3;
    localparam logic [4:0] CODE_LAST_SHFT = 5'd5;
    localparam logic [4:0] CODE_ESCAPE    = 5'd6;

    // alphabets
    localparam logic [1:0] ALPHA_LOWER = 2'd0;
    localparam logic [1:0] ALPHA_UPPER = 2'd1;
    localparam logic [1:0] ALPHA_PUNCT = 2'd2;

    // escape phases
    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    localparam int RESULTS_MAX = 3;

    // one decoded result
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } zctd_res_t;

    // everything one text word produces, res[0] delivered first
    typedef struct packed {
        zctd_res_t [RESULTS_MAX-1:0] res;
        logic [1:0]                  cnt;
        logic                        str_end;
    } zctd_bundle_t;

    // punctuation alphabet, codes 6..31
    localparam logic [7:0] PUNCT_TABLE [26] = '{
        8'h00, 8'h0d, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h2e, 8'h2c, 8'h21, 8'h3f, 8'h5f, 8'h23, 8'h27, 8'h22,
        8'h2f, 8'h5c, 8'h2d, 8'h3a, 8'h28, 8'h29
    };

    // character for a code 6..31 in the given alphabet
    function automatic logic [7:0] alpha_char(input logic [1:0] alpha, input logic [4:0] code);
        logic [4:0] ofs;
        logic [7:0] ch;
        ofs = code - CODE_ESCAPE;
        case (alpha)
            ALPHA_LOWER: ch = 8'h61 + {3'd0, ofs};
            ALPHA_UPPER: ch = 8'h41 + {3'd0, ofs};
            default:     ch = (ofs < 5'd26) ? PUNCT_TABLE[ofs] : 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### src/zctd_front.sv
// ----------------------------------------------------------------------------
// zctd_front
// accepts text words, decodes the three codes and pushes one result bundle
// ----------------------------------------------------------------------------
module zctd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,      // text_word
    input  logic                  q_full,
    output logic                  q_push,
    output zctd_pkg::zctd_bundle_t q_data
);

    logic [1:0] shift_reg, shift_next;
    logic [1:0] bank_reg,  bank_next;
    logic [1:0] esc_reg,   esc_next;
    logic [4:0] high_reg,  high_next;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // three dependent code steps over the small decode state
    always_comb begin
        logic [1:0] sh, ab, ep, n;
        logic [4:0] eh, code;
        zctd_pkg::zctd_res_t [zctd_pkg::RESULTS_MAX-1:0] res;
        sh = shift_reg;
        ab = bank_reg;
        ep = esc_reg;
        eh = high_reg;
        n  = 2'd0;
        res = '0;
        for (int pos = 0; pos < zctd_pkg::RESULTS_MAX; pos++) begin
            code = s_tdata[14 - 5*pos -: 5];
            if (ep == zctd_pkg::ESC_HIGH) begin
                eh = code;
                ep = zctd_pkg::ESC_LOW;
            end else if (ep != zctd_pkg::ESC_IDLE) begin
                res[n] = '{kind: zctd_pkg::KIND_CHAR, value: {eh[2:0], code}};
                n  = n + 2'd1;
                ep = zctd_pkg::ESC_IDLE;
                eh = 5'd0;
                sh = zctd_pkg::ALPHA_LOWER;
            end else if (ab != 2'd0) begin
                res[n] = '{kind: zctd_pkg::KIND_ABBREV, value: {1'b0, ab - 2'd1, code}};
                n  = n + 2'd1;
                ab = 2'd0;
            end else if (code == zctd_pkg::CODE_SPACE) begin
                res[n] = '{kind: zctd_pkg::KIND_CHAR, value: 8'h20};
                n  = n + 2'd1;
                sh = zctd_pkg::ALPHA_LOWER;
            end else if (code <= zctd_pkg::CODE_LAST_ABBR) begin
                ab = code[1:0];
            end else if (code <= zctd_pkg::CODE_LAST_SHFT) begin
                sh = code[1:0] - 2'd3;
            end else if (code == zctd_pkg::CODE_ESCAPE && sh == zctd_pkg::ALPHA_PUNCT) begin
                ep = zctd_pkg::ESC_HIGH;
            end else begin
                res[n] = '{kind: zctd_pkg::KIND_CHAR, value: zctd_pkg::alpha_char(sh, code)};
                n  = n + 2'd1;
                sh = zctd_pkg::ALPHA_LOWER;
            end
        end
        // a word that yields nothing still reports once
        if (n == 2'd0) begin
            res[0] = '{kind: zctd_pkg::KIND_NONE, value: 8'h00};
            n = 2'd1;
        end
        q_data.res     = res;
        q_data.cnt     = n;
        q_data.str_end = s_tdata[15];
        // end of string drops all pending decode state
        if (s_tdata[15]) begin
            shift_next = zctd_pkg::ALPHA_LOWER;
            bank_next  = 2'd0;
            esc_next   = zctd_pkg::ESC_IDLE;
            high_next  = 5'd0;
        end else begin
            shift_next = sh;
            bank_next  = ab;
            esc_next   = ep;
            high_next  = eh;
        end
    end

    // decode state, updated on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= zctd_pkg::ALPHA_LOWER;
            bank_reg  <= 2'd0;
            esc_reg   <= zctd_pkg::ESC_IDLE;
            high_reg  <= 5'd0;
        end else if (q_push) begin
            shift_reg <= shift_next;
            bank_reg  <= bank_next;
            esc_reg   <= esc_next;
            high_reg  <= high_next;
        end
    end

endmodule

### src/zctd_fifo.sv
// ----------------------------------------------------------------------------
// zctd_fifo
// short bundle queue between the decode front and the output back
// ----------------------------------------------------------------------------
module zctd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  zctd_pkg::zctd_bundle_t push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   empty,
    output zctd_pkg::zctd_bundle_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    zctd_pkg::zctd_bundle_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/zctd_back.sv
// ----------------------------------------------------------------------------
// zctd_back
// walks each queued bundle and delivers one result beat per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module zctd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_empty,
    input  zctd_pkg::zctd_bundle_t q_head,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,     // value[7:0], string_end[8], zero
    output logic [1:0]             m_tuser,     // kind[1:0]
    output logic                   m_tlast
);

    logic [1:0]  idx_reg,    idx_next;
    logic        valid_reg,  valid_next;
    logic [15:0] data_reg,   data_next;
    logic [1:0]  user_reg,   user_next;
    logic        last_reg,   last_next;
    logic        load, final_res;
    zctd_pkg::zctd_res_t cur;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    assign load      = !valid_reg || m_tready;
    assign cur       = q_head.res[idx_reg];
    assign final_res = (idx_reg == q_head.cnt - 2'd1);
    assign q_pop     = load && !q_empty && final_res;

    // output register refill
    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = !q_empty;
            if (!q_empty) begin
                data_next = {7'd0, final_res && q_head.str_end, cur.value};
                user_next = cur.kind;
                last_next = final_res;
                idx_next  = final_res ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

endmodule

### src/zchar_text_decoder_core.sv
// ----------------------------------------------------------------------------
// zchar_text_decoder_core
// packed text word decoder with result serializer
// ----------------------------------------------------------------------------
// Input stream s_*: one 16-bit packed text word per beat (bit 15 end of
// string, then three 5-bit codes high first).
// Output stream m_*: one result per beat. tuser carries the kind (character,
// abbreviation request, nothing), tdata[7:0] the byte or abbreviation index,
// tdata[8] string end, tlast marks the final result of each word.
// A word is decoded in the cycle it is accepted and queued as a bundle of
// one to three results; its first result reaches m_* through the queue
// and the output register. Input words are taken every cycle while the
// bundle queue has room. Output runs at one result per cycle while the
// receiver is ready, so a word producing k results takes k output beats;
// that serializer sets sustained rate. When the receiver stalls, the output
// beat holds and the queue fills; s_tready drops once FIFO_DEPTH bundles
// wait. Reset (aresetn low, synchronous) empties the queue and returns the
// decode state to alphabet 0 with no abbreviation or escape pending.
// ----------------------------------------------------------------------------
module zchar_text_decoder_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // text_word[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // value[7:0], string_end[8], zero[15:9]
    output logic [1:0]  m_tuser,    // kind[1:0]
    output logic        m_tlast
);

    logic                   q_full, q_empty, q_push, q_pop;
    zctd_pkg::zctd_bundle_t q_in, q_head;

    // decode front
    zctd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // bundle queue
    zctd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // output back
    zctd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### src/zctd_checker.sv
// ----------------------------------------------------------------------------
// zctd_checker
// port-level checks on the decoder result stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zctd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    logic        s_beat;
    logic        out_stall;
    logic [18:0] m_beat_bits;
    logic        is_char, is_none, abbr_ok;

    assign s_beat      = s_tvalid && s_tready && (s_tdata[15] || !s_tdata[15]);
    assign out_stall   = m_tvalid && !m_tready;
    assign m_beat_bits = {m_tdata, m_tuser, m_tlast};
    assign is_char     = (m_tuser == zctd_pkg::KIND_CHAR);
    assign is_none     = (m_tuser == zctd_pkg::KIND_NONE);
    assign abbr_ok     = (m_tuser == zctd_pkg::KIND_ABBREV) && (m_tdata[7:0] < 8'd96);

    // stalled result beat holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_beat_bits))

    // string end only on the final result of a word
    `ASSERT_IMPLY(a_end_last, aclk, aresetn, m_tvalid && m_tdata[8], m_tlast)

    // an empty-word report is a lone zero beat
    `ASSERT_IMPLY(a_none_last, aclk, aresetn, m_tvalid && is_none, m_tlast && m_tdata[7:0] == 8'h00)

    // abbreviation indices stay below 96, kind code 3 never shows
    `ASSERT_IMPLY(a_abbr_range, aclk, aresetn, m_tvalid && !is_char, abbr_ok || is_none)

    // no result shows up on an idle output unless an input beat reached the bundle queue first
    `ASSERT_NEXT(a_no_spurious, aclk, aresetn, !m_tvalid && !s_beat && !$past(s_beat), !m_tvalid)

endmodule

bind zchar_text_decoder_core zctd_checker u_zctd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
